// ===== hw/rtl/dvt_pkg.sv =====
// Shared types and constants of the distance-vector routing table unit.
package dvt_pkg;

    localparam int ROUTERS_DEFAULT = 8;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int IDX_FIELD_W     = 3;
    localparam int COST_W          = 16;

    localparam logic signed [COST_W-1:0] COST_NONE = -16'sd1;
    localparam logic signed [COST_W-1:0] COST_MAX  = 16'sd32767;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ADV   = 2'd1,
        CMD_RESET = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [IDX_FIELD_W-1:0]   router;
        logic [IDX_FIELD_W-1:0]   dest;
        logic signed [COST_W-1:0] cost;
        logic                     last;
    } item_t;

    typedef struct packed {
        logic                     has_route;
        logic [IDX_FIELD_W-1:0]   next_hop;
        logic signed [COST_W-1:0] route_cost;
        logic                     changed;
    } result_t;

endpackage

// ===== hw/rtl/dvt_cfg.sv =====
// APB register block holding the router's own index.
module dvt_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dvt_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [dvt_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [dvt_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [dvt_pkg::IDX_FIELD_W-1:0]     self_index
);
    import dvt_pkg::*;

    localparam logic REG_SELF_INDEX = 1'b0;

    logic [IDX_FIELD_W-1:0] self_index_reg;
    logic [IDX_FIELD_W-1:0] self_index_next;
    logic                   reg_sel;
    logic                   wr_en;

    // Registers sit on 32-bit word boundaries.
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        self_index_next = self_index_reg;
        if (wr_en && (reg_sel == REG_SELF_INDEX)) begin
            self_index_next = pwdata[IDX_FIELD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            self_index_reg <= '0;
        end else begin
            self_index_reg <= self_index_next;
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SELF_INDEX: prdata = {{(CFG_DATA_W-IDX_FIELD_W){1'b0}}, self_index_reg};
            default:        prdata = '0;
        endcase
    end

    assign self_index = self_index_reg;

endmodule

// ===== hw/rtl/dvt_table.sv =====
// Live and saved routing tables with the per-command update and query logic.
module dvt_table #(
    parameter int ROUTERS = dvt_pkg::ROUTERS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step_en,
    input  dvt_pkg::item_t                  item,
    input  logic [dvt_pkg::IDX_FIELD_W-1:0] self_index,
    output dvt_pkg::result_t                result
);
    import dvt_pkg::*;

    localparam int IDX_W = (ROUTERS > 1) ? $clog2(ROUTERS) : 1;

    typedef struct packed {
        logic                     usable;
        logic                     hop_known;
        logic [IDX_FIELD_W-1:0]   hop;
        logic signed [COST_W-1:0] cost;
    } route_t;

    localparam route_t ROUTE_INIT = '{usable: 1'b1, hop_known: 1'b0,
                                      hop: '0, cost: COST_NONE};

    route_t                   live_reg  [ROUTERS];
    route_t                   live_next [ROUTERS];
    route_t                   saved_reg [ROUTERS];
    route_t                   saved_next[ROUTERS];
    logic [ROUTERS-1:0]       mask_reg;
    logic [ROUTERS-1:0]       mask_next;
    logic signed [COST_W-1:0] pending_reg;
    logic signed [COST_W-1:0] pending_next;
    logic                     vchg_reg;
    logic                     vchg_next;

    logic [IDX_W-1:0]         rt_i;
    logic [IDX_W-1:0]         d_i;
    logic                     rt_ok;
    logic                     d_ok;
    logic signed [COST_W-1:0] adv_cost;
    logic signed [COST_W-1:0] via;
    logic signed [COST_W-1:0] orig;
    logic [COST_W:0]          sum_wide;
    logic [COST_W-1:0]        sum;
    logic                     take;
    route_t                   load_entry;
    route_t                   qry;

    function automatic logic signed [COST_W-1:0] cost_of(input route_t e);
        return e.usable ? e.cost : COST_NONE;
    endfunction

    assign rt_i     = IDX_W'(item.router);
    assign d_i      = IDX_W'(item.dest);
    assign rt_ok    = int'(item.router) < ROUTERS;
    assign d_ok     = int'(item.dest) < ROUTERS;
    // Any negative cost on the input means no route.
    assign adv_cost = item.cost[COST_W-1] ? COST_NONE : item.cost;

    always_comb begin
        live_next    = live_reg;
        saved_next   = saved_reg;
        mask_next    = mask_reg;
        pending_next = pending_reg;
        vchg_next    = vchg_reg;
        via          = COST_NONE;
        orig         = COST_NONE;
        sum_wide     = '0;
        sum          = '0;
        take         = 1'b0;
        load_entry   = '{usable: 1'b1, hop_known: 1'b1, hop: item.dest, cost: adv_cost};
        qry          = live_reg[d_i];
        result       = '{has_route: 1'b0, next_hop: '0, route_cost: COST_NONE,
                         changed: 1'b0};

        if (step_en) begin
            unique case (item.cmd)
                CMD_LOAD: begin
                    if (d_ok) begin
                        live_next[d_i]  = load_entry;
                        saved_next[d_i] = load_entry;
                        mask_next[d_i]  = 1'b1;
                    end
                end
                CMD_ADV: begin
                    if (rt_ok) begin
                        // Hearing from a neighbor that was declared dead revives it.
                        if (!saved_reg[rt_i].usable) begin
                            saved_next[rt_i].usable = 1'b1;
                            live_next[rt_i].usable  = 1'b1;
                            vchg_next               = 1'b1;
                        end
                        if (item.dest == self_index) begin
                            pending_next = adv_cost;
                        end else if (d_ok) begin
                            via  = cost_of(live_next[rt_i]);
                            orig = cost_of(live_next[d_i]);
                            if (!via[COST_W-1] && !adv_cost[COST_W-1]) begin
                                sum_wide = {1'b0, via} + {1'b0, adv_cost};
                                sum = (sum_wide > (COST_W+1)'(COST_MAX)) ? COST_MAX
                                                                        : sum_wide[COST_W-1:0];
                                if (orig[COST_W-1] || (sum < orig)) begin
                                    take = 1'b1;
                                end else if (sum == orig) begin
                                    // Ties go to the lower-numbered sender.
                                    take = live_next[d_i].hop_known &&
                                           (live_next[d_i].hop > item.router);
                                end
                                if (take) begin
                                    live_next[d_i].cost      = sum;
                                    live_next[d_i].hop       = item.router;
                                    live_next[d_i].hop_known = 1'b1;
                                    vchg_next                = 1'b1;
                                end
                            end
                        end
                        if (item.last) begin
                            live_next[rt_i].cost = pending_next;
                        end
                    end
                    if (item.last) begin
                        result.changed = vchg_next;
                        vchg_next      = 1'b0;
                        pending_next   = COST_NONE;
                    end
                end
                CMD_RESET: begin
                    if (rt_ok && mask_reg[rt_i] && (cost_of(saved_reg[rt_i]) != COST_NONE)) begin
                        saved_next[rt_i].usable = 1'b0;
                    end
                    live_next = saved_next;
                end
                CMD_QUERY: begin
                    if (d_ok) begin
                        if (qry.usable && qry.hop_known) begin
                            result.has_route = 1'b1;
                            result.next_hop  = qry.hop;
                        end
                        result.route_cost = cost_of(qry);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ROUTERS; i++) begin
                live_reg[i]  <= ROUTE_INIT;
                saved_reg[i] <= ROUTE_INIT;
            end
            mask_reg    <= '0;
            pending_reg <= COST_NONE;
            vchg_reg    <= 1'b0;
        end else begin
            live_reg    <= live_next;
            saved_reg   <= saved_next;
            mask_reg    <= mask_next;
            pending_reg <= pending_next;
            vchg_reg    <= vchg_next;
        end
    end

    logic [ROUTERS-1:0] usable_match;
    logic [ROUTERS-1:0] cost_ok;

    always_comb begin
        for (int i = 0; i < ROUTERS; i++) begin
            usable_match[i] = (live_reg[i].usable == saved_reg[i].usable);
            cost_ok[i]      = !live_reg[i].cost[COST_W-1] || (live_reg[i].cost == COST_NONE);
        end
    end

`ifndef SYNTHESIS
    // The live usable flags always track the saved ones.
    a_usable_match: assert property (@(posedge aclk) disable iff (!aresetn)
        &usable_match)
        else $error("live and saved usable flags differ");

    // A stored cost is either a real cost or the no-route mark.
    a_cost_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        &cost_ok)
        else $error("live table holds a negative cost other than no route");

    // The end of a vector leaves the per-vector state cleared.
    a_vector_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && (item.cmd == CMD_ADV) && item.last)
        |=> (!vchg_reg && (pending_reg == COST_NONE)))
        else $error("vector state not cleared after last element");
`endif

endmodule

// ===== hw/rtl/distance_vector_table_update_unit.sv =====
// Top level of the distance-vector routing table: input and result registers.
//
//  Port group   Direction  Handshake          Payload
//  s_*          in         s_valid/s_ready    s_data  (dvt_pkg::item_t)
//  m_*          out        m_valid/m_ready    m_data  (dvt_pkg::result_t)
//  APB          in/out     psel/penable       paddr, pwdata, prdata
//
// One transaction is taken per cycle while the result register is not stalled.
// The table update happens as a transaction moves from the input register to the
// result register, so each transaction sees every earlier one applied.
// A stalled result register holds the input register; s_ready stays high while
// the input register is empty or can move on. Reset is synchronous and restores
// the table at once.
module distance_vector_table_update_unit #(
    parameter int ROUTERS = dvt_pkg::ROUTERS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  dvt_pkg::item_t                 s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output dvt_pkg::result_t               m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dvt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dvt_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dvt_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import dvt_pkg::*;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    item_t                  in_data_reg;
    item_t                  in_data_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                out_data_reg;
    result_t                out_data_next;
    logic                   advance;
    logic [IDX_FIELD_W-1:0] self_index;
    result_t                step_result;

    dvt_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .self_index (self_index)
    );

    dvt_table #(
        .ROUTERS (ROUTERS)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .item       (in_data_reg),
        .self_index (self_index),
        .result     (step_result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_data_next   = in_data_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_data_next  = s_data;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
            out_data_next  = step_result;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== tb/tb_distance_vector_table_update_unit.sv =====
// Self-checking testbench of the distance-vector routing table update unit.
`timescale 1ns / 100ps

module tb_distance_vector_table_update_unit;

    import dvt_pkg::*;

    localparam int ROUTERS      = ROUTERS_DEFAULT;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_ITEMS  = 160;
    localparam int ITEM_W       = $bits(item_t);

    localparam logic [CFG_ADDR_W-1:0] ADDR_SELF_INDEX = '0;

    typedef struct packed {
        logic                     usable;
        logic                     hop_known;
        logic [IDX_FIELD_W-1:0]   hop;
        logic signed [COST_W-1:0] cost;
    } route_entry_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    item_t                 s_data;
    logic                  m_valid;
    logic                  m_ready;
    result_t               m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Table copy kept by the testbench.
    route_entry_t             live_rt [ROUTERS];
    route_entry_t             saved_rt[ROUTERS];
    logic [ROUTERS-1:0]       nbr_mask;
    logic signed [COST_W-1:0] back_cost;
    logic                     vec_changed;
    logic [IDX_FIELD_W-1:0]   my_index;

    item_t   item_q[$];
    result_t route_q[$];

    int errors;
    int n_in;
    int n_out;
    int n_changed;
    int n_routes;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int hold_req;
    int hold_done;
    int hold_left;
    int pat_left;
    int stall_pct;
    bit calm;
    int phase;
    int i;
    logic [IDX_FIELD_W-1:0] phase_sel;

    distance_vector_table_update_unit #(
        .ROUTERS(ROUTERS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic int eff_cost(route_entry_t e);
        return e.usable ? int'(e.cost) : -1;
    endfunction

    // Applies one transaction to the table copy and returns the result it produces.
    function automatic result_t table_step(item_t it);
        result_t res;
        int      c;
        int      orig;
        int      via;
        int      sum;
        bit      take;
        int      rt;
        int      d;
        res.has_route  = 1'b0;
        res.next_hop   = '0;
        res.route_cost = COST_NONE;
        res.changed    = 1'b0;
        rt = int'(it.router);
        d  = int'(it.dest);
        c  = it.cost[COST_W-1] ? -1 : int'(it.cost);
        case (it.cmd)
            CMD_LOAD: begin
                live_rt[d].usable    = 1'b1;
                live_rt[d].hop_known = 1'b1;
                live_rt[d].hop       = it.dest;
                live_rt[d].cost      = COST_W'(c);
                saved_rt[d]          = live_rt[d];
                nbr_mask[d]          = 1'b1;
            end
            CMD_ADV: begin
                if (!saved_rt[rt].usable) begin
                    saved_rt[rt].usable = 1'b1;
                    live_rt[rt].usable  = 1'b1;
                    vec_changed         = 1'b1;
                end
                if (it.dest == my_index) begin
                    back_cost = COST_W'(c);
                end else begin
                    // Bellman-Ford relaxation through the sender.
                    orig = eff_cost(live_rt[d]);
                    via  = eff_cost(live_rt[rt]);
                    if (via >= 0 && c >= 0) begin
                        sum = via + c;
                        if (sum > int'(COST_MAX)) sum = int'(COST_MAX);
                        if (orig < 0 || sum <= orig) begin
                            take = (orig < 0 || sum < orig) ||
                                   (live_rt[d].hop_known && int'(live_rt[d].hop) > rt);
                            live_rt[d].cost = COST_W'(sum);
                            if (take) begin
                                live_rt[d].hop       = it.router;
                                live_rt[d].hop_known = 1'b1;
                                vec_changed          = 1'b1;
                            end
                        end
                    end
                end
                if (it.last) begin
                    live_rt[rt].cost = back_cost;
                    res.changed      = vec_changed;
                    vec_changed      = 1'b0;
                    back_cost        = COST_NONE;
                end
            end
            CMD_RESET: begin
                if (nbr_mask[rt] && eff_cost(saved_rt[rt]) != -1)
                    saved_rt[rt].usable = 1'b0;
                for (int k = 0; k < ROUTERS; k++) live_rt[k] = saved_rt[k];
            end
            default: begin
                if (live_rt[d].usable && live_rt[d].hop_known) begin
                    res.has_route = 1'b1;
                    res.next_hop  = live_rt[d].hop;
                end
                res.route_cost = COST_W'(eff_cost(live_rt[d]));
            end
        endcase
        return res;
    endfunction

    // Driver: bursts of transactions separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                route_q.insert(route_q.size(), table_step(s_data));
                n_in++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0 && !calm) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (item_q.size() > 0) begin
                    s_data  <= item_q.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result against the oldest expectation and stalls the output.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_out++;
                if (route_q.size() == 0) begin
                    errors++;
                    $display("%0t: result without a pending transaction: %p", $time, m_data);
                end else begin
                    result_t exp_r;
                    exp_r = route_q.pop_front();
                    if (m_data.has_route !== exp_r.has_route) begin
                        errors++;
                        $display("%0t: has_route expected %0b actual %0b",
                                 $time, exp_r.has_route, m_data.has_route);
                    end
                    if (m_data.next_hop !== exp_r.next_hop) begin
                        errors++;
                        $display("%0t: next_hop expected %0d actual %0d",
                                 $time, exp_r.next_hop, m_data.next_hop);
                    end
                    if (m_data.route_cost !== exp_r.route_cost) begin
                        errors++;
                        $display("%0t: route_cost expected %0d actual %0d",
                                 $time, exp_r.route_cost, m_data.route_cost);
                    end
                    if (m_data.changed !== exp_r.changed) begin
                        errors++;
                        $display("%0t: changed expected %0b actual %0b",
                                 $time, exp_r.changed, m_data.changed);
                    end
                    if (exp_r.changed) n_changed++;
                    if (exp_r.has_route) n_routes++;
                end
            end
            if (hold_done != hold_req) begin
                hold_done = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                if (pat_left == 0) begin
                    pat_left = 48;
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                pat_left--;
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                    $display("tb_distance_vector_table_update_unit: FAIL");
                    $finish;
                end
            end
        end
    end

    task automatic push_item(cmd_t c, int r, int d, int cst, int l);
        item_t it;
        it.cmd    = c;
        it.router = IDX_FIELD_W'(r);
        it.dest   = IDX_FIELD_W'(d);
        it.cost   = COST_W'(cst);
        it.last   = (l != 0);
        item_q.insert(item_q.size(), it);
    endtask

    function automatic int rand_cost();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 20);
            5:             return $urandom_range(32000, 32767);
            6:             return -1;
            7:             return int'($signed({1'b1, 15'($urandom)}));
            default:       return int'($signed(16'($urandom)));
        endcase
    endfunction

    task automatic add_random(int n);
        int     cnt;
        int     sel;
        int     rt;
        int     dl[$];
        item_t  it;
        cnt = 0;
        while (cnt < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                push_item(CMD_LOAD, $urandom_range(0, 7), $urandom_range(0, 7), rand_cost(),
                          $urandom_range(0, 1));
                cnt++;
            end else if (sel < 55) begin
                // A vector in destination order, a few elements dropped.
                rt = $urandom_range(0, ROUTERS - 1);
                dl.delete();
                for (int d = 0; d < ROUTERS; d++)
                    if ($urandom_range(0, 6) != 0) dl.insert(dl.size(), d);
                if (dl.size() == 0) dl.insert(0, $urandom_range(0, ROUTERS - 1));
                foreach (dl[k]) begin
                    push_item(CMD_ADV, rt, dl[k], rand_cost(), int'(k == dl.size() - 1));
                    cnt++;
                end
            end else if (sel < 65) begin
                push_item(CMD_RESET, $urandom_range(0, 7), $urandom_range(0, 7), rand_cost(),
                          $urandom_range(0, 1));
                cnt++;
            end else if (sel < 90) begin
                push_item(CMD_QUERY, $urandom_range(0, 7), $urandom_range(0, 7), rand_cost(),
                          $urandom_range(0, 1));
                cnt++;
            end else begin
                it = item_t'(ITEM_W'($urandom));
                item_q.insert(item_q.size(), it);
                cnt++;
            end
        end
    endtask

    task automatic wait_for_idle();
        while (item_q.size() != 0 || s_valid || route_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        errors      = 0;
        n_in        = 0;
        n_out       = 0;
        n_changed   = 0;
        n_routes    = 0;
        idle_cycles = 0;
        burst_left  = 0;
        gap_left    = 0;
        hold_req    = 0;
        hold_done   = 0;
        hold_left   = 0;
        pat_left    = 0;
        stall_pct   = 0;
        calm        = 1'b0;
        for (i = 0; i < ROUTERS; i++) begin
            live_rt[i]  = '{usable: 1'b1, hop_known: 1'b0, hop: '0, cost: COST_NONE};
            saved_rt[i] = live_rt[i];
        end
        nbr_mask    = '0;
        back_cost   = COST_NONE;
        vec_changed = 1'b0;
        my_index    = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       phase_sel = '0;
                1:       phase_sel = '1;
                default: phase_sel = IDX_FIELD_W'($urandom_range(0, 7));
            endcase
            if (phase > 0) wait_for_idle();
            apb_write(ADDR_SELF_INDEX, CFG_DATA_W'(phase_sel));
            my_index = phase_sel;
            calm     = (phase == 3);
            if (phase == 0) begin
                push_item(CMD_QUERY, 0, 0, 0, 0);
                push_item(CMD_QUERY, 7, 7, -1, 1);
                push_item(CMD_LOAD,  0, 1, 5, 0);
                push_item(CMD_LOAD,  0, 2, 3, 0);
                push_item(CMD_LOAD,  0, 7, 32767, 0);
                push_item(CMD_LOAD,  0, 3, -32768, 0);
                // Sender 2 sets the route to 4, then sender 1 ties it with a lower index.
                push_item(CMD_ADV, 2, 0, 3, 0);
                push_item(CMD_ADV, 2, 4, 12, 1);
                push_item(CMD_ADV, 1, 0, 5, 0);
                push_item(CMD_ADV, 1, 4, 10, 0);
                push_item(CMD_ADV, 1, 5, 32767, 0);
                push_item(CMD_ADV, 1, 6, -1, 0);
                push_item(CMD_ADV, 1, 7, 2, 1);
                // This vector has no element for self, so the cost to sender 2 is lost.
                push_item(CMD_ADV, 2, 6, 1, 1);
                push_item(CMD_QUERY, 0, 4, 0, 0);
                push_item(CMD_QUERY, 0, 5, 0, 0);
                push_item(CMD_QUERY, 0, 6, 0, 0);
                push_item(CMD_QUERY, 0, 7, 0, 0);
                push_item(CMD_RESET, 1, 0, 0, 0);
                push_item(CMD_QUERY, 0, 1, 0, 0);
                push_item(CMD_RESET, 6, 0, 0, 0);
                push_item(CMD_RESET, 3, 0, 0, 0);
                // A dead neighbor that advertises again becomes usable.
                push_item(CMD_ADV, 1, 0, 5, 1);
                push_item(CMD_QUERY, 0, 1, 0, 0);
                push_item(CMD_QUERY, 0, 3, 0, 0);
            end
            add_random(PHASE_ITEMS);
            if (phase == 2) hold_req++;
        end

        wait_for_idle();
        if (route_q.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, route_q.size());
        end
        $display("Ran %0d transactions in and %0d results out over five self indexes,",
                 n_in, n_out);
        $display("with %0d routed queries and %0d vectors that changed the table.",
                 n_routes, n_changed);
        if (errors == 0) begin
            $display("tb_distance_vector_table_update_unit: PASS");
        end else begin
            $display("tb_distance_vector_table_update_unit: FAIL");
        end
        $finish;
    end

endmodule

// ===== distance_vector_table_update_unit.f =====
hw/rtl/dvt_pkg.sv
hw/rtl/dvt_cfg.sv
hw/rtl/dvt_table.sv
hw/rtl/distance_vector_table_update_unit.sv
tb/tb_distance_vector_table_update_unit.sv
